/* rtl/csvq_pkg.sv */
package csvq_pkg;

    // count fields in the command word, wide enough for the largest capacity (31)
    localparam int CNT_W       = 5;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_CR    = 8'h0d;
    localparam logic [7:0] CH_LF    = 8'h0a;

    // register indexes
    localparam logic [2:0] CFG_QUOTE_STYLE  = 3'd0;
    localparam logic [2:0] CFG_DELIM_LENGTH = 3'd1;
    localparam logic [2:0] CFG_DELIM_FIRST  = 3'd2;
    localparam logic [2:0] CFG_DELIM_SECOND = 3'd3;
    localparam logic [2:0] CFG_TERM_LENGTH  = 3'd4;
    localparam logic [2:0] CFG_TERM_FIRST   = 3'd5;
    localparam logic [2:0] CFG_TERM_SECOND  = 3'd6;

    // quoting styles
    localparam logic [1:0] STYLE_NONE    = 2'd0;
    localparam logic [1:0] STYLE_MINIMAL = 2'd1;
    localparam logic [1:0] STYLE_RFC     = 2'd2;
    localparam logic [1:0] STYLE_ALWAYS  = 2'd3;

    typedef struct packed {
        logic [1:0] quote_style;
        logic [1:0] delim_length;
        logic [7:0] delim_first;
        logic [7:0] delim_second;
        logic [1:0] term_length;
        logic [7:0] term_first;
        logic [7:0] term_second;
    } t_cfg;

    // one classified input word, front to back
    typedef struct packed {
        logic             wr;
        logic [CNT_W-1:0] wr_addr;
        logic [7:0]       wr_data;
        logic             flush;
        logic             emit_delim;
        logic             wrap;
        logic             dbl;
        logic             ovf;
        logic [CNT_W-1:0] cnt;
        logic             rec_end;
    } t_cmd;

    typedef enum logic [3:0] {
        S_IDLE   = 4'd0,
        S_DELIM1 = 4'd1,
        S_DELIM2 = 4'd2,
        S_OQUOTE = 4'd3,
        S_BODY   = 4'd4,
        S_DQUOTE = 4'd5,
        S_CQUOTE = 4'd6,
        S_TERM1  = 4'd7,
        S_TERM2  = 4'd8
    } t_bstate;

    // a length code of three acts as two
    function automatic logic [1:0] f_eff_len(input logic [1:0] len);
        return (len == 2'd3) ? 2'd2 : len;
    endfunction

endpackage

/* rtl/csvq_front.sv */
module csvq_front #(
    parameter int FIELD_CAPACITY = 16
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  csvq_pkg::t_cfg  i_cfg,
    input  logic            i_valid,
    output logic            o_stall,
    input  logic [7:0]      i_data_byte,
    input  logic            i_has_byte,
    input  logic            i_field_end,
    input  logic            i_record_end,
    input  logic            i_full,
    output logic            o_push,
    output csvq_pkg::t_cmd  o_cmd
);
    import csvq_pkg::*;

    localparam int CW = $clog2(FIELD_CAPACITY + 1);

    logic [CW-1:0] r_count, n_count;
    logic          r_seen_quote, n_seen_quote;
    logic          r_seen_nl, n_seen_nl;
    logic          r_seen_delim, n_seen_delim;
    logic [7:0]    r_prev, n_prev;
    logic          r_first, n_first;
    logic          r_lost, n_lost;

    logic          load_ok;
    logic          q1, nl1, dm1, lost1;
    logic [CW-1:0] cnt1;
    logic [1:0]    dl;
    logic          accept;

    assign o_stall = i_full;
    assign accept  = i_valid && !i_full;
    assign o_push  = accept;

    always_comb begin
        dl      = f_eff_len(i_cfg.delim_length);
        load_ok = i_has_byte && (r_count < CW'(FIELD_CAPACITY));
        q1      = r_seen_quote | (load_ok && i_data_byte == CH_QUOTE);
        nl1     = r_seen_nl | (load_ok && (i_data_byte == CH_CR || i_data_byte == CH_LF));
        dm1     = r_seen_delim
                | (load_ok && dl == 2'd1 && i_data_byte == i_cfg.delim_first)
                | (load_ok && dl == 2'd2 && r_count != '0
                   && r_prev == i_cfg.delim_first && i_data_byte == i_cfg.delim_second);
        lost1   = r_lost | (i_has_byte && !load_ok);
        cnt1    = r_count + CW'(load_ok);

        o_cmd.wr         = load_ok;
        o_cmd.wr_addr    = CNT_W'(r_count);
        o_cmd.wr_data    = i_data_byte;
        o_cmd.flush      = i_field_end;
        o_cmd.emit_delim = !r_first;
        o_cmd.ovf        = i_field_end && lost1;
        o_cmd.cnt        = CNT_W'(cnt1);
        o_cmd.rec_end    = i_record_end;
        if (i_cfg.quote_style == STYLE_NONE) begin
            o_cmd.wrap = 1'b0;
            o_cmd.dbl  = 1'b0;
        end else begin
            o_cmd.wrap = (i_cfg.quote_style == STYLE_ALWAYS) | q1 | nl1 | dm1;
            o_cmd.dbl  = q1 && (i_cfg.quote_style >= STYLE_RFC);
        end

        n_count      = r_count;
        n_seen_quote = r_seen_quote;
        n_seen_nl    = r_seen_nl;
        n_seen_delim = r_seen_delim;
        n_prev       = r_prev;
        n_first      = r_first;
        n_lost       = r_lost;
        if (accept) begin
            if (i_field_end) begin
                n_count      = '0;
                n_seen_quote = 1'b0;
                n_seen_nl    = 1'b0;
                n_seen_delim = 1'b0;
                n_prev       = '0;
                n_lost       = 1'b0;
                n_first      = 1'b0;
            end else begin
                n_count      = cnt1;
                n_seen_quote = q1;
                n_seen_nl    = nl1;
                n_seen_delim = dm1;
                n_lost       = lost1;
                if (load_ok) begin
                    n_prev = i_data_byte;
                end
            end
            if (i_record_end) begin
                n_first = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count      <= '0;
            r_seen_quote <= 1'b0;
            r_seen_nl    <= 1'b0;
            r_seen_delim <= 1'b0;
            r_prev       <= '0;
            r_first      <= 1'b1;
            r_lost       <= 1'b0;
        end else begin
            r_count      <= n_count;
            r_seen_quote <= n_seen_quote;
            r_seen_nl    <= n_seen_nl;
            r_seen_delim <= n_seen_delim;
            r_prev       <= n_prev;
            r_first      <= n_first;
            r_lost       <= n_lost;
        end
    end

endmodule

/* rtl/csvq_queue.sv */
module csvq_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  csvq_pkg::t_cmd i_data,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_empty,
    output csvq_pkg::t_cmd o_data
);
    import csvq_pkg::*;

    localparam int PW = $clog2(QUEUE_DEPTH);
    localparam int FW = $clog2(QUEUE_DEPTH + 1);

    t_cmd          r_mem [QUEUE_DEPTH];
    logic [PW-1:0] r_wp, r_rp;
    logic [FW-1:0] r_fill;

    assign o_full  = (r_fill == FW'(QUEUE_DEPTH));
    assign o_empty = (r_fill == '0);
    assign o_data  = r_mem[r_rp];

    function automatic logic [PW-1:0] f_inc(input logic [PW-1:0] p);
        return (p == PW'(QUEUE_DEPTH - 1)) ? '0 : p + PW'(1);
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp   <= '0;
            r_rp   <= '0;
            r_fill <= '0;
        end else begin
            if (i_push) begin
                r_wp <= f_inc(r_wp);
            end
            if (i_pop) begin
                r_rp <= f_inc(r_rp);
            end
            if (i_push && !i_pop) begin
                r_fill <= r_fill + FW'(1);
            end else if (i_pop && !i_push) begin
                r_fill <= r_fill - FW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

endmodule

/* rtl/csvq_back.sv */
module csvq_back #(
    parameter int FIELD_CAPACITY = 16
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  csvq_pkg::t_cfg i_cfg,
    input  logic           i_empty,
    input  csvq_pkg::t_cmd i_cmd,
    output logic           o_pop,
    output logic           o_valid,
    input  logic           i_stall,
    output logic [7:0]     o_out_byte,
    output logic           o_run_last,
    output logic [15:0]    o_record_bytes,
    output logic           o_overflowed
);
    import csvq_pkg::*;

    localparam int AW = $clog2(FIELD_CAPACITY);

    logic [7:0]    r_field [FIELD_CAPACITY];
    t_bstate       r_state, n_state, emit_next;
    t_cmd          r_cmd;
    logic [AW-1:0] r_idx;
    logic [15:0]   r_rec;
    logic [15:0]   rec_inc;

    logic          r_o_valid;
    logic [7:0]    r_o_byte;
    logic          r_o_last;
    logic [15:0]   r_o_rec;
    logic          r_o_ovf;

    logic [8:0]    en_new, en_cur;
    logic [7:0]    byte_rd;
    logic          is_dq, more, adv, emitting, last;
    logic [7:0]    e_byte;
    logic [15:0]   e_rec;

    function automatic logic [8:0] f_en(input t_cmd c, input t_cfg g);
        logic [8:0] e;
        logic [1:0] dl;
        logic [1:0] tl;
        dl          = f_eff_len(g.delim_length);
        tl          = f_eff_len(g.term_length);
        e           = '0;
        e[S_DELIM1] = c.flush && c.emit_delim && dl >= 2'd1;
        e[S_DELIM2] = c.flush && c.emit_delim && dl >= 2'd2;
        e[S_OQUOTE] = c.flush && c.wrap;
        e[S_BODY]   = c.flush && c.cnt != '0;
        e[S_CQUOTE] = c.flush && c.wrap;
        e[S_TERM1]  = c.rec_end && tl >= 2'd1;
        e[S_TERM2]  = c.rec_end && tl >= 2'd2;
        return e;
    endfunction

    // first enabled step at or after s
    function automatic t_bstate f_first(input t_bstate s, input logic [8:0] e);
        t_bstate res;
        res = S_IDLE;
        for (int k = 8; k >= 1; k--) begin
            if (k >= int'(s) && e[k]) begin
                res = t_bstate'(4'(k));
            end
        end
        return res;
    endfunction

    assign adv      = !r_o_valid || !i_stall;
    assign emitting = (r_state != S_IDLE);
    assign byte_rd  = r_field[r_idx];
    assign rec_inc  = (r_rec == 16'hffff) ? r_rec : r_rec + 16'd1;

    // step after the current one
    always_comb begin
        en_new    = f_en(i_cmd, i_cfg);
        en_cur    = f_en(r_cmd, i_cfg);
        is_dq     = r_cmd.dbl && byte_rd == CH_QUOTE;
        more      = (CNT_W'(r_idx) + CNT_W'(1)) < r_cmd.cnt;
        emit_next = S_IDLE;
        case (r_state)
            S_DELIM1: emit_next = f_first(S_DELIM2, en_cur);
            S_DELIM2: emit_next = f_first(S_OQUOTE, en_cur);
            S_OQUOTE: emit_next = f_first(S_BODY, en_cur);
            S_BODY: begin
                if (is_dq) begin
                    emit_next = S_DQUOTE;
                end else if (more) begin
                    emit_next = S_BODY;
                end else begin
                    emit_next = f_first(S_CQUOTE, en_cur);
                end
            end
            S_DQUOTE: emit_next = more ? S_BODY : f_first(S_CQUOTE, en_cur);
            S_CQUOTE: emit_next = f_first(S_TERM1, en_cur);
            S_TERM1:  emit_next = f_first(S_TERM2, en_cur);
            default:  emit_next = S_IDLE;
        endcase
    end

    // next state
    always_comb begin
        n_state = r_state;
        o_pop   = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (!i_empty) begin
                    o_pop   = 1'b1;
                    n_state = f_first(S_DELIM1, en_new);
                end
            end
            default: begin
                if (adv) begin
                    n_state = emit_next;
                end
            end
        endcase
    end

    // outputs of the current step
    always_comb begin
        last = (emit_next == S_IDLE);
        case (r_state)
            S_DELIM1: e_byte = i_cfg.delim_first;
            S_DELIM2: e_byte = i_cfg.delim_second;
            S_OQUOTE, S_DQUOTE, S_CQUOTE: e_byte = CH_QUOTE;
            S_BODY:   e_byte = byte_rd;
            S_TERM1:  e_byte = i_cfg.term_first;
            S_TERM2:  e_byte = i_cfg.term_second;
            default:  e_byte = '0;
        endcase
        e_rec = ((r_state == S_TERM1 || r_state == S_TERM2) && last) ? rec_inc : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_rec     <= '0;
            r_o_valid <= 1'b0;
            r_idx     <= '0;
        end else begin
            r_state <= n_state;
            if (o_pop) begin
                r_idx <= '0;
                if (n_state == S_IDLE && i_cmd.rec_end) begin
                    r_rec <= '0;
                end
            end
            if (emitting && adv) begin
                r_o_valid <= 1'b1;
                r_rec     <= (last && r_cmd.rec_end) ? '0 : rec_inc;
                if ((r_state == S_BODY && !is_dq) || r_state == S_DQUOTE) begin
                    r_idx <= r_idx + AW'(1);
                end
            end else if (!i_stall) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_cmd <= i_cmd;
        end
        if (o_pop && i_cmd.wr) begin
            r_field[i_cmd.wr_addr[AW-1:0]] <= i_cmd.wr_data;
        end
        if (emitting && adv) begin
            r_o_byte <= e_byte;
            r_o_last <= last;
            r_o_rec  <= e_rec;
            r_o_ovf  <= r_cmd.ovf;
        end
    end

    assign o_valid        = r_o_valid;
    assign o_out_byte     = r_o_byte;
    assign o_run_last     = r_o_last;
    assign o_record_bytes = r_o_rec;
    assign o_overflowed   = r_o_ovf;

endmodule

/* rtl/csv_record_field_quoter.sv */
// csv record writer: field bytes come in one word at a time and CSV text goes out one
// byte per word. the front classifies each input word in its cycle of acceptance and
// puts one command into a two-entry queue, so it takes a new word every cycle while
// the queue has room. the back sequencer takes a command while idle and then emits its
// output bytes in order: for a field flush the delimiter bytes, the field bytes with quotes
// doubled where needed and, if the field is wrapped, an opening and a closing quote around
// them, then the terminator bytes at a record end. a word that only loads a byte passes
// the back through its idle state alone. the output register lets the back run ahead by
// one byte while the sink stalls. configuration writes are taken every cycle (ready is
// tied high) and must only happen while the block is idle.
module csv_record_field_quoter #(
    parameter int FIELD_CAPACITY = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration write channel
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [7:0]  i_cfg_data,
    // input channel
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_data_byte,
    input  logic        i_has_byte,
    input  logic        i_field_end,
    input  logic        i_record_end,
    // output channel
    output logic        o_valid,
    input  logic        i_stall,
    output logic [7:0]  o_out_byte,
    output logic        o_run_last,
    output logic [15:0] o_record_bytes,
    output logic        o_overflowed
);
    import csvq_pkg::*;

    // register values after reset: rfc4180 quoting, comma, line feed
    localparam logic [1:0] RST_QUOTE_STYLE  = STYLE_RFC;
    localparam logic [1:0] RST_DELIM_LENGTH = 2'd1;
    localparam logic [7:0] RST_DELIM_FIRST  = 8'd44;
    localparam logic [7:0] RST_DELIM_SECOND = 8'd0;
    localparam logic [1:0] RST_TERM_LENGTH  = 2'd1;
    localparam logic [7:0] RST_TERM_FIRST   = 8'd10;
    localparam logic [7:0] RST_TERM_SECOND  = 8'd0;

    t_cfg r_cfg;
    t_cmd push_cmd, head_cmd;
    logic push, pop, q_full, q_empty;

    assign o_cfg_ready = 1'b1;

    // configuration registers, unknown indexes are ignored
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.quote_style  <= RST_QUOTE_STYLE;
            r_cfg.delim_length <= RST_DELIM_LENGTH;
            r_cfg.delim_first  <= RST_DELIM_FIRST;
            r_cfg.delim_second <= RST_DELIM_SECOND;
            r_cfg.term_length  <= RST_TERM_LENGTH;
            r_cfg.term_first   <= RST_TERM_FIRST;
            r_cfg.term_second  <= RST_TERM_SECOND;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_QUOTE_STYLE:  r_cfg.quote_style  <= i_cfg_data[1:0];
                CFG_DELIM_LENGTH: r_cfg.delim_length <= i_cfg_data[1:0];
                CFG_DELIM_FIRST:  r_cfg.delim_first  <= i_cfg_data;
                CFG_DELIM_SECOND: r_cfg.delim_second <= i_cfg_data;
                CFG_TERM_LENGTH:  r_cfg.term_length  <= i_cfg_data[1:0];
                CFG_TERM_FIRST:   r_cfg.term_first   <= i_cfg_data;
                CFG_TERM_SECOND:  r_cfg.term_second  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // front: field bookkeeping and quoting decision
    csvq_front #(
        .FIELD_CAPACITY(FIELD_CAPACITY)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_data_byte  (i_data_byte),
        .i_has_byte   (i_has_byte),
        .i_field_end  (i_field_end),
        .i_record_end (i_record_end),
        .i_full       (q_full),
        .o_push       (push),
        .o_cmd        (push_cmd)
    );

    // command queue between the two halves
    csvq_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_cmd),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_empty (q_empty),
        .o_data  (head_cmd)
    );

    // back: field buffer and byte sequencer
    csvq_back #(
        .FIELD_CAPACITY(FIELD_CAPACITY)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (r_cfg),
        .i_empty        (q_empty),
        .i_cmd          (head_cmd),
        .o_pop          (pop),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_out_byte     (o_out_byte),
        .o_run_last     (o_run_last),
        .o_record_bytes (o_record_bytes),
        .o_overflowed   (o_overflowed)
    );

`ifndef ASSERT_OFF
    // the record count only rides on the closing byte of a run
    a_rec_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_record_bytes != 16'd0) |-> o_run_last)
        else $error("record count outside the last byte of a run");

    // the loss flag is the same on every byte of one run
    a_ovf_steady: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_stall && !o_run_last) |=>
            (!o_valid || o_overflowed == $past(o_overflowed)))
        else $error("overflow flag changed within a run");

    // nothing is presented straight after reset
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output word valid after reset");
`endif

endmodule
